FILE: rtl/core/pqu_pkg.sv
// Package for the priority queue with update-key: sizes, action and mode codes,
// the entry and cell command types, and the priority compare.
// No dependencies.
package pqu_pkg;

	localparam int NUM_SLOTS  = 64;
	localparam int LEVEL_MIN  = 30;
	localparam int LEVEL_MAX  = 100;
	localparam int ORDER_BITS = 32;

	localparam int ID_W    = 6;
	localparam int AMT_W   = 7;
	localparam int LEVEL_W = $clog2(LEVEL_MAX + 1);
	localparam int SUM_W   = ((LEVEL_W > AMT_W) ? LEVEL_W : AMT_W) + 1;

	// Action codes of an input transaction
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_RAISE  = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_QUERY  = 2'd3;

	// Chain update modes broadcast to every cell
	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_RAISE  = 2'd2;
	localparam logic [1:0] MODE_REMOVE = 2'd3;

	typedef struct packed {
		logic                  valid;
		logic [ID_W-1:0]       id;
		logic [LEVEL_W-1:0]    level;
		logic [ORDER_BITS-1:0] order;
	} entry_t;

	typedef struct packed {
		logic [1:0] mode;
		entry_t     new_key;
		entry_t     old_key;
	} cell_cmd_t;

	// a ranks strictly ahead of b: higher level, then earlier stamp, then lower id
	function automatic logic beats(entry_t a, entry_t b);
		logic res;
		res = (a.level > b.level) ||
		      ((a.level == b.level) && (a.order < b.order)) ||
		      ((a.level == b.level) && (a.order == b.order) && (a.id < b.id));
		return res;
	endfunction

endpackage

FILE: rtl/core/priority_queue_update_key.sv
// Priority queue with update-key: control, lookup and the sorted chain of cells.
// Depends on pqu_pkg and pqu_cell.
//
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high
//   and busy low; action, entry_id and amount are sampled there.
//   Actions: insert (level clamped to 30..100, stamped with a rising arrival
//   number), raise (level increased, saturating at 100), remove, and query.
//   Result channel: done is high for exactly one cycle per transaction with
//   queue_empty, best_entry and op_error. The receiver cannot stall it.
//   Timing: the accept cycle looks the id up in the chain; the next cycle
//   (busy high) shifts the chain; the result shows in the cycle after that.
//   No new transaction is taken while busy is high, as the single chain
//   must do its lookup and then its shift for each one.
//   The chain keeps entries sorted best first, so a query reads the head cell.
//   Insert of a present id, raise or remove of an absent id, and any id at or
//   above the slot count are ignored with op_error set.
//   Reset: arst_n clears every cell, the arrival counter and the result
//   strobe; the block is ready, with busy low, once reset is released.
module priority_queue_update_key (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    action,
	input  logic [pqu_pkg::ID_W-1:0]      entry_id,
	input  logic [pqu_pkg::AMT_W-1:0]     amount,
	output logic                          done,
	output logic                          queue_empty,
	output logic [pqu_pkg::ID_W-1:0]      best_entry,
	output logic                          op_error
);

	localparam int N = pqu_pkg::NUM_SLOTS;

	logic                              apply_q;
	logic [1:0]                        act_q;
	logic [pqu_pkg::ID_W-1:0]          id_q;
	logic [pqu_pkg::AMT_W-1:0]         amt_q;
	logic                              in_range_q;
	logic                              present_q;
	logic [pqu_pkg::LEVEL_W-1:0]       old_level_q;
	logic [pqu_pkg::ORDER_BITS-1:0]    old_order_q;
	logic [pqu_pkg::ORDER_BITS-1:0]    arrival_q;

	logic                              done_q;
	logic                              empty_q;
	logic [pqu_pkg::ID_W-1:0]          best_q;
	logic                              err_q;

	logic                              accept;
	logic                              hit;
	logic [pqu_pkg::LEVEL_W-1:0]       hit_level;
	logic [pqu_pkg::ORDER_BITS-1:0]    hit_order;
	logic                              err;
	logic [pqu_pkg::SUM_W-1:0]         amt_ext;
	logic [pqu_pkg::SUM_W-1:0]         ins_level;
	logic [pqu_pkg::SUM_W-1:0]         raise_sum;
	logic [pqu_pkg::SUM_W-1:0]         raise_level;
	pqu_pkg::cell_cmd_t                cmd;

	pqu_pkg::entry_t                   cell_entry [N];
	logic [N-1:0]                      cell_ahead;
	logic [N-1:0]                      cell_match;
	logic [N-1:0]                      cell_valid;

	assign accept = start && !busy;
	assign busy   = apply_q;

	// Chain of cells, head at index 0
	for (genvar i = 0; i < N; i++) begin : g_cell
		pqu_pkg::entry_t left_e;
		pqu_pkg::entry_t right_e;
		logic            left_a;

		if (i == 0) begin : g_head
			assign left_e = '0;
			assign left_a = 1'b1;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_a = cell_ahead[i-1];
		end
		if (i == N - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_body
			assign right_e = cell_entry[i+1];
		end

		pqu_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.lookup_id   (entry_id),
			.left_entry  (left_e),
			.left_ahead  (left_a),
			.right_entry (right_e),
			.entry       (cell_entry[i]),
			.ahead       (cell_ahead[i]),
			.match       (cell_match[i])
		);

		assign cell_valid[i] = cell_entry[i].valid;
	end

	// Lookup of the requested id: at most one cell matches
	always_comb begin
		hit       = 1'b0;
		hit_level = '0;
		hit_order = '0;
		for (int i = 0; i < N; i++) begin
			hit       = hit | cell_match[i];
			hit_level = hit_level | (cell_match[i] ? cell_entry[i].level : '0);
			hit_order = hit_order | (cell_match[i] ? cell_entry[i].order : '0);
		end
	end

	// Accept stage: capture the transaction and the lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			apply_q <= 1'b0;
		else
			apply_q <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q       <= action;
			id_q        <= entry_id;
			amt_q       <= amount;
			in_range_q  <= 32'(entry_id) < 32'(N);
			present_q   <= hit;
			old_level_q <= hit_level;
			old_order_q <= hit_order;
		end
	end

	// Error and new levels
	always_comb begin
		err = 1'b0;
		if (act_q != pqu_pkg::ACT_QUERY) begin
			if (!in_range_q)
				err = 1'b1;
			else if (act_q == pqu_pkg::ACT_INSERT)
				err = present_q;
			else
				err = !present_q;
		end

		amt_ext   = pqu_pkg::SUM_W'(amt_q);
		ins_level = amt_ext;
		if (ins_level < pqu_pkg::SUM_W'(pqu_pkg::LEVEL_MIN))
			ins_level = pqu_pkg::SUM_W'(pqu_pkg::LEVEL_MIN);
		if (ins_level > pqu_pkg::SUM_W'(pqu_pkg::LEVEL_MAX))
			ins_level = pqu_pkg::SUM_W'(pqu_pkg::LEVEL_MAX);

		raise_sum   = pqu_pkg::SUM_W'(old_level_q) + amt_ext;
		raise_level = (raise_sum > pqu_pkg::SUM_W'(pqu_pkg::LEVEL_MAX)) ?
		              pqu_pkg::SUM_W'(pqu_pkg::LEVEL_MAX) : raise_sum;
	end

	// Chain command
	always_comb begin
		cmd.mode            = pqu_pkg::MODE_NONE;
		cmd.old_key.valid   = 1'b1;
		cmd.old_key.id      = id_q;
		cmd.old_key.level   = old_level_q;
		cmd.old_key.order   = old_order_q;
		cmd.new_key.valid   = 1'b1;
		cmd.new_key.id      = id_q;
		cmd.new_key.level   = raise_level[pqu_pkg::LEVEL_W-1:0];
		cmd.new_key.order   = old_order_q;
		if (act_q == pqu_pkg::ACT_INSERT) begin
			cmd.new_key.level = ins_level[pqu_pkg::LEVEL_W-1:0];
			cmd.new_key.order = arrival_q + pqu_pkg::ORDER_BITS'(1);
		end
		if (apply_q && !err) begin
			case (act_q)
				pqu_pkg::ACT_INSERT: cmd.mode = pqu_pkg::MODE_INSERT;
				pqu_pkg::ACT_RAISE:  cmd.mode = pqu_pkg::MODE_RAISE;
				pqu_pkg::ACT_REMOVE: cmd.mode = pqu_pkg::MODE_REMOVE;
				default:             cmd.mode = pqu_pkg::MODE_NONE;
			endcase
		end
	end

	// Arrival counter and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrival_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= apply_q;
			if (cmd.mode == pqu_pkg::MODE_INSERT)
				arrival_q <= arrival_q + pqu_pkg::ORDER_BITS'(1);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (apply_q) begin
			err_q   <= err;
			empty_q <= (act_q == pqu_pkg::ACT_QUERY) && !cell_entry[0].valid;
			best_q  <= ((act_q == pqu_pkg::ACT_QUERY) && cell_entry[0].valid) ?
			           cell_entry[0].id : '0;
		end
	end

	assign done        = done_q;
	assign queue_empty = empty_q;
	assign best_entry  = best_q;
	assign op_error    = err_q;

	// Chain update never runs back to back
	a_apply_single: assert property (@(posedge clk) disable iff (!arst_n)
		apply_q |=> !apply_q)
		else $error("chain update lasted more than one cycle");

	// Result follows the chain update
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		apply_q |=> done_q)
		else $error("no result after chain update");

	// Occupied cells form a prefix of the chain
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, cell_valid} + (N + 1)'(1)))
		else $error("hole in the sorted chain");

	// A query never reports an error
	a_query_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (act_q == pqu_pkg::ACT_QUERY)) |-> !err_q)
		else $error("query reported an error");

endmodule

FILE: rtl/core/pqu_cell.sv
// One cell of the sorted chain: holds one entry and shifts left, right or
// loads the broadcast key as the chain command requires.
// Depends on pqu_pkg.
module pqu_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  pqu_pkg::cell_cmd_t cmd,
	input  logic [pqu_pkg::ID_W-1:0] lookup_id,
	input  pqu_pkg::entry_t    left_entry,
	input  logic               left_ahead,
	input  pqu_pkg::entry_t    right_entry,
	output pqu_pkg::entry_t    entry,
	output logic               ahead,
	output logic               match
);

	pqu_pkg::entry_t entry_q;
	pqu_pkg::entry_t entry_next;
	logic            ahead_old;
	logic            is_old;

	// Local compares against the new and the old key
	assign ahead     = entry_q.valid && pqu_pkg::beats(entry_q, cmd.new_key);
	assign ahead_old = entry_q.valid && pqu_pkg::beats(entry_q, cmd.old_key);
	assign is_old    = entry_q.valid && (entry_q.id == cmd.old_key.id);
	assign match     = entry_q.valid && (entry_q.id == lookup_id);

	// Next content
	always_comb begin
		entry_next = entry_q;
		case (cmd.mode)
			pqu_pkg::MODE_INSERT: begin
				if (!ahead)
					entry_next = left_ahead ? cmd.new_key : left_entry;
			end
			pqu_pkg::MODE_RAISE: begin
				if ((ahead_old || is_old) && !ahead)
					entry_next = left_ahead ? cmd.new_key : left_entry;
			end
			pqu_pkg::MODE_REMOVE: begin
				if (!ahead_old)
					entry_next = right_entry;
			end
			default: begin
				entry_next = entry_q;
			end
		endcase
	end

	// Entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			entry_q <= '0;
		else
			entry_q <= entry_next;
	end

	assign entry = entry_q;

endmodule
